// ===== design/lgsw_pkg.sv =====
// Package for the LED grid serial writer: sequencer state, result and request
// types, phase and request codes, register indexes, opcodes and widths.
// No dependencies.
package lgsw_pkg;

   localparam int MAX_GRIDS_DEF = 16;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int POS_W    = 4;
   localparam int SEG_W    = 8;
   localparam int INT_W    = 8;
   localparam int GRID_W   = 5;
   localparam int PHASE_W  = 4;
   localparam int BYTEC_W  = 6;
   localparam int CSR_W    = 5;

   // Sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
   localparam logic [PHASE_W-1:0] PH_BITS   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_GAP    = 4'd2;
   localparam logic [PHASE_W-1:0] PH_STOP   = 4'd3;
   localparam logic [PHASE_W-1:0] PH_START2 = 4'd4;

   // Request kinds
   localparam logic [CMD_W-1:0] CMD_IDLE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTROL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

   // Register indexes
   localparam logic CSR_GRID_COUNT = 1'b0;
   localparam logic CSR_WIDE_GRIDS = 1'b1;

   // Driver opcodes
   localparam logic [7:0] OP_DATA_AUTO  = 8'h40;
   localparam logic [7:0] OP_DATA_FIXED = 8'h44;
   localparam logic [7:0] OP_ADDRESS    = 8'hC0;
   localparam logic [7:0] OP_DISPLAY    = 8'h80;
   localparam logic [7:0] DOT_BIT       = 8'b1000_0000;
   localparam logic [7:0] FILL_BYTE     = 8'h00;
   localparam logic [7:0] MAX_LEVEL     = 8'd7;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [BYTEC_W-1:0] byte_cnt;
      logic [2:0]         bit_cnt;
      logic [1:0]         tick;
      logic [7:0]         shift;
      logic [SEG_W-1:0]   held_seg;
      logic [POS_W-1:0]   held_addr;
      logic               strobe;
      logic               clk;
      logic               data;
      logic [CMD_W-1:0]   kind;
      logic               frame_no;
      logic [BYTEC_W-1:0] frame2_len;
   } seq_state_type;

   typedef struct packed {
      logic strobe_pin;
      logic clock_pin;
      logic data_pin;
      logic busy_res;
      logic rejected;
   } result_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [POS_W-1:0] position;
      logic [SEG_W-1:0] segments;
      logic             dot;
      logic             display_on;
      logic [INT_W-1:0] intensity;
   } request_type;

endpackage

// ===== design/led_grid_serial_writer_unit.sv =====
// LED grid serial writer: top level with the sequencer state, the
// configuration registers and a two-deep result buffer.
// Depends on lgsw_pkg and lgsw_step.
//
// Usage
//  - Each request on the req_ channel is one tick of the strobe/clock/data
//    waveform; command 0 is a plain tick. Send one request per tick.
//  - Every accepted request gives exactly one response on rsp_: the pin
//    levels after that tick, busy and rejected flags.
//  - The response is registered: in the response register, or in the skid register under a stall.
//  - Throughput: one request per clock while req_stall is low. The tick is
//    worked out in one pass of the step logic between the state registers
//    and the response register.
//  - A response stall is absorbed by a skid register; req_stall rises only
//    once both response slots are full, so nothing is lost or repeated.
//  - Reset (synchronous, active high): sequencer idle, strobe and clock
//    high, data low, grid_count 16, wide_grids 0, response buffer empty.
//  - csr_ writes land at once; a clear latches its length when accepted.
module led_grid_serial_writer_unit #(
   parameter int MAX_GRIDS = lgsw_pkg::MAX_GRIDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lgsw_pkg::CMD_W-1:0]    req_command,
   input  logic [lgsw_pkg::POS_W-1:0]    req_position,
   input  logic [lgsw_pkg::SEG_W-1:0]    req_segments,
   input  logic                          req_dot,
   input  logic                          req_display_on,
   input  logic [lgsw_pkg::INT_W-1:0]    req_intensity,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_strobe_pin,
   output logic                          rsp_clock_pin,
   output logic                          rsp_data_pin,
   output logic                          rsp_busy_res,
   output logic                          rsp_rejected,
   // configuration
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [lgsw_pkg::CSR_W-1:0]    csr_wdata
);

   lgsw_pkg::seq_state_type state_ff, state_in;
   lgsw_pkg::request_type   req;
   lgsw_pkg::result_type    res_new;
   lgsw_pkg::result_type    out_ff, skid_ff;
   logic                    out_valid_ff, skid_valid_ff;
   logic [lgsw_pkg::GRID_W-1:0] grid_count_ff;
   logic                    wide_grids_ff;
   logic                    req_fire;
   logic                    out_free;

   assign req = '{command: req_command, position: req_position, segments: req_segments,
                  dot: req_dot, display_on: req_display_on, intensity: req_intensity};

   lgsw_step #(.MAX_GRIDS(MAX_GRIDS)) u_step (
      .cur        (state_ff),
      .req        (req),
      .grid_count (grid_count_ff),
      .wide_grids (wide_grids_ff),
      .nxt        (state_in),
      .res        (res_new)
   );

   // stall only when the skid slot is occupied
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // sequencer state advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: lgsw_pkg::PH_IDLE, byte_cnt: '0, bit_cnt: '0, tick: '0,
                       shift: '0, held_seg: '0, held_addr: '0, strobe: 1'b1, clk: 1'b1,
                       data: 1'b0, kind: lgsw_pkg::CMD_IDLE, frame_no: 1'b0,
                       frame2_len: '0};
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_count_ff <= lgsw_pkg::GRID_W'(16);
         wide_grids_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lgsw_pkg::CSR_GRID_COUNT: grid_count_ff <= csr_wdata[lgsw_pkg::GRID_W-1:0];
            default:                  wide_grids_ff <= csr_wdata[0];
         endcase
      end
   end

   // response register plus skid: order kept, skid drains first
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_fire;
         end
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_fire) begin
            out_ff <= res_new;
         end
      end else if (req_fire) begin
         skid_ff <= res_new;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_strobe_pin = out_ff.strobe_pin;
   assign rsp_clock_pin  = out_ff.clock_pin;
   assign rsp_data_pin   = out_ff.data_pin;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_rejected   = out_ff.rejected;

endmodule

// ===== design/lgsw_step.sv =====
// One tick of the serial sequencer: next state and pin result.
// Depends on lgsw_pkg.
module lgsw_step #(
   parameter int MAX_GRIDS = lgsw_pkg::MAX_GRIDS_DEF
) (
   input  lgsw_pkg::seq_state_type     cur,
   input  lgsw_pkg::request_type       req,
   input  logic [lgsw_pkg::GRID_W-1:0] grid_count,
   input  logic                        wide_grids,
   output lgsw_pkg::seq_state_type     nxt,
   output lgsw_pkg::result_type        res
);

   localparam logic [lgsw_pkg::GRID_W-1:0] MAXG = lgsw_pkg::GRID_W'(MAX_GRIDS);

   logic [lgsw_pkg::GRID_W-1:0]  grids;
   logic [lgsw_pkg::BYTEC_W-1:0] bc_inc;
   logic [lgsw_pkg::BYTEC_W-1:0] flen;
   logic [7:0]                   level;
   logic                         busy;
   logic                         rej;

   always_comb begin
      grids  = (grid_count > MAXG) ? MAXG : grid_count;
      bc_inc = cur.byte_cnt + lgsw_pkg::BYTEC_W'(1);
      flen   = cur.frame_no ? cur.frame2_len : lgsw_pkg::BYTEC_W'(1);
      level  = (req.intensity > lgsw_pkg::MAX_LEVEL) ? lgsw_pkg::MAX_LEVEL : req.intensity;
      nxt    = cur;
      busy   = 1'b0;
      rej    = 1'b0;

      if (cur.phase != lgsw_pkg::PH_IDLE) begin
         busy = 1'b1;
         rej  = (req.command != lgsw_pkg::CMD_IDLE);
         unique case (cur.phase)
            lgsw_pkg::PH_BITS: begin
               unique case (cur.tick)
                  2'd0: begin
                     nxt.clk  = 1'b0;
                     nxt.tick = 2'd1;
                  end
                  2'd1: begin
                     nxt.data  = cur.shift[0];
                     nxt.shift = {1'b0, cur.shift[7:1]};
                     nxt.tick  = 2'd2;
                  end
                  default: begin
                     nxt.clk  = 1'b1;
                     nxt.tick = 2'd0;
                     if (cur.bit_cnt == 3'd7) begin
                        nxt.phase = lgsw_pkg::PH_GAP;
                     end else begin
                        nxt.bit_cnt = cur.bit_cnt + 3'd1;
                     end
                  end
               endcase
            end
            lgsw_pkg::PH_GAP: begin
               nxt.byte_cnt = bc_inc;
               if (bc_inc < flen) begin
                  nxt.shift   = (cur.kind == lgsw_pkg::CMD_WRITE) ? cur.held_seg
                                                                  : lgsw_pkg::FILL_BYTE;
                  nxt.bit_cnt = 3'd0;
                  nxt.tick    = 2'd0;
                  nxt.phase   = lgsw_pkg::PH_BITS;
               end else begin
                  nxt.phase = lgsw_pkg::PH_STOP;
               end
            end
            lgsw_pkg::PH_STOP: begin
               nxt.strobe = 1'b1;
               if (!cur.frame_no && cur.kind != lgsw_pkg::CMD_CONTROL) begin
                  nxt.frame_no = 1'b1;
                  nxt.phase    = lgsw_pkg::PH_START2;
               end else begin
                  nxt.phase = lgsw_pkg::PH_IDLE;
               end
            end
            lgsw_pkg::PH_START2: begin
               nxt.strobe   = 1'b0;
               nxt.byte_cnt = '0;
               nxt.shift    = lgsw_pkg::OP_ADDRESS | {4'h0, cur.held_addr};
               nxt.bit_cnt  = 3'd0;
               nxt.tick     = 2'd0;
               nxt.phase    = lgsw_pkg::PH_BITS;
            end
            default: nxt.phase = lgsw_pkg::PH_IDLE;
         endcase
      end else if (req.command != lgsw_pkg::CMD_IDLE) begin
         // a write past the grids in use is dropped
         if (req.command == lgsw_pkg::CMD_WRITE &&
             lgsw_pkg::GRID_W'(req.position) >= grids) begin
            rej = 1'b1;
         end else begin
            busy         = 1'b1;
            nxt.kind     = req.command;
            nxt.frame_no = 1'b0;
            nxt.byte_cnt = '0;
            nxt.strobe   = 1'b0;
            nxt.bit_cnt  = 3'd0;
            nxt.tick     = 2'd0;
            nxt.phase    = lgsw_pkg::PH_BITS;
            unique case (req.command)
               lgsw_pkg::CMD_WRITE: begin
                  nxt.held_addr  = req.position;
                  nxt.held_seg   = req.segments | (req.dot ? lgsw_pkg::DOT_BIT : 8'h00);
                  nxt.frame2_len = lgsw_pkg::BYTEC_W'(2);
                  nxt.shift      = lgsw_pkg::OP_DATA_FIXED;
               end
               lgsw_pkg::CMD_CONTROL: begin
                  nxt.frame2_len = '0;
                  nxt.shift      = lgsw_pkg::OP_DISPLAY | {4'h0, req.display_on, level[2:0]};
               end
               default: begin
                  nxt.held_addr  = '0;
                  nxt.frame2_len = (lgsw_pkg::BYTEC_W'(grids) << wide_grids)
                                   + lgsw_pkg::BYTEC_W'(1);
                  nxt.shift      = lgsw_pkg::OP_DATA_AUTO;
               end
            endcase
         end
      end

      res.strobe_pin = nxt.strobe;
      res.clock_pin  = nxt.clk;
      res.data_pin   = nxt.data;
      res.busy_res   = busy;
      res.rejected   = rej;
   end

endmodule
